@@ design/tnss_pkg.sv @@
package tnss_pkg;

  // ring geometry
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MAX_EVENTS = 32;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  // field widths
  localparam int TIME_W  = 18;
  localparam int LEN_W   = 16;
  localparam int PITCH_W = 16;
  localparam int SOUND_W = 8;
  localparam int SLOTF_W = 4;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ONSET = 1'b0;
  localparam logic REG_TRANS = 1'b1;

  // item codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic EV_START  = 1'b0;
  localparam logic EV_STOP   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD2,
    ST_READ,
    ST_EVAL,
    ST_STOP,
    ST_FLUSH
  } ctrl_state_e;

  // one stored slot
  typedef struct packed {
    logic [SOUND_W-1:0]        sound;
    logic [TIME_W-1:0]         start;
    logic [LEN_W-1:0]          length;
    logic signed [PITCH_W-1:0] pitch;
  } slot_t;

  // one event on its way out
  typedef struct packed {
    logic                      kind;
    logic [SLOTF_W-1:0]        slot;
    logic [SOUND_W-1:0]        sound;
    logic signed [PITCH_W-1:0] pitch;
  } event_t;

  typedef struct packed {
    logic load;
    logic wr_first;
    logic wr_second;
    logic idx_inc;
    logic push_start;
    logic push_stop;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic func;
    logic vowel_only;
    logic eligible;
    logic do_start;
    logic do_stop;
    logic can_push;
    logic idx_last;
    logic pend_v;
  } dp_status_t;

endpackage

@@ design/tnss_note_if.sv @@
interface tnss_note_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        func;
  logic [tnss_pkg::TIME_W-1:0]                 now_time;
  logic [tnss_pkg::TIME_W-1:0]                 start_time;
  logic [tnss_pkg::LEN_W-1:0]                  note_length;
  logic signed [tnss_pkg::PITCH_W-1:0]         pitch;
  logic [tnss_pkg::SOUND_W-1:0]                onset_sound;
  logic [tnss_pkg::SOUND_W-1:0]                vowel_sound;
  logic                                        vowel_only;

  modport source (
    output valid, func, now_time, start_time, note_length, pitch,
           onset_sound, vowel_sound, vowel_only,
    input  ready
  );

  modport sink (
    input  valid, func, now_time, start_time, note_length, pitch,
           onset_sound, vowel_sound, vowel_only,
    output ready
  );
endinterface

@@ design/tnss_evt_if.sv @@
interface tnss_evt_if;
  logic                                valid;
  logic                                ready;
  logic                                event_kind;
  logic [tnss_pkg::SLOTF_W-1:0]        slot;
  logic [tnss_pkg::SOUND_W-1:0]        sound;
  logic signed [tnss_pkg::PITCH_W-1:0] pitch_out;
  logic                                last;

  modport source (
    output valid, event_kind, slot, sound, pitch_out, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, slot, sound, pitch_out, last,
    output ready
  );
endinterface

@@ design/tnss_ctrl.sv @@
module tnss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tnss_pkg::dp_status_t sts_i,
  output tnss_pkg::ctrl_cmd_t  cmd_o
);

  tnss_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tnss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    logic next_slot;
    next_slot  = 1'b0;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tnss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.func == tnss_pkg::FUNC_ADD) begin
            cmd_o.wr_first = 1'b1;
            if (!sts_i.vowel_only) begin
              state_d = tnss_pkg::ST_ADD2;
            end
          end else begin
            state_d = tnss_pkg::ST_READ;
          end
        end
      end
      tnss_pkg::ST_ADD2: begin
        cmd_o.wr_second = 1'b1;
        state_d         = tnss_pkg::ST_IDLE;
      end
      tnss_pkg::ST_READ: begin
        state_d = tnss_pkg::ST_EVAL;
      end
      tnss_pkg::ST_EVAL: begin
        if (!sts_i.eligible) begin
          next_slot = 1'b1;
        end else if (sts_i.do_start) begin
          if (sts_i.can_push) begin
            cmd_o.push_start = 1'b1;
            if (sts_i.do_stop) begin
              state_d = tnss_pkg::ST_STOP;
            end else begin
              next_slot = 1'b1;
            end
          end
        end else if (sts_i.do_stop) begin
          state_d = tnss_pkg::ST_STOP;
        end else begin
          next_slot = 1'b1;
        end
      end
      tnss_pkg::ST_STOP: begin
        if (sts_i.can_push) begin
          cmd_o.push_stop = 1'b1;
          next_slot       = 1'b1;
        end
      end
      tnss_pkg::ST_FLUSH: begin
        if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          state_d     = tnss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tnss_pkg::ST_IDLE;
      end
    endcase

    // advance the scan or finish the tick
    if (next_slot) begin
      if (sts_i.idx_last) begin
        state_d = tnss_pkg::ST_FLUSH;
      end else begin
        cmd_o.idx_inc = 1'b1;
        state_d       = tnss_pkg::ST_READ;
      end
    end
  end

endmodule

@@ design/tnss_dp.sv @@
module tnss_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tnss_note_if.sink                      note_i,
  tnss_evt_if.source                     evt_o,
  input  logic                           in_ready_i,
  input  logic [tnss_pkg::LEN_W-1:0]     onset_i,
  input  logic [tnss_pkg::LEN_W-1:0]     trans_i,
  input  tnss_pkg::ctrl_cmd_t            cmd_i,
  output tnss_pkg::dp_status_t           sts_o
);

  localparam int SW = tnss_pkg::SLOT_W;
  localparam int CW = tnss_pkg::CNT_W;

  // slot payload store
  tnss_pkg::slot_t mem [tnss_pkg::SLOT_COUNT];
  tnss_pkg::slot_t rd_q;

  logic [tnss_pkg::SLOT_COUNT-1:0] playing_q, playing_d;
  logic [tnss_pkg::SLOT_COUNT-1:0] started_q, started_d;
  logic [SW-1:0]                   wp_q, wp_d;
  logic [SW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [tnss_pkg::TIME_W-1:0]     now_q;
  tnss_pkg::slot_t                 vowel_q;

  tnss_pkg::event_t                pend_q, out_q, push_ev;
  logic                            pend_v_q, pend_v_d;
  logic                            out_v_q, out_v_d;
  logic                            out_last_q;
  logic                            out_free, push, load_out;

  // add item arithmetic
  logic [tnss_pkg::LEN_W-1:0]      first_len, vowel_len;
  logic [tnss_pkg::TIME_W-1:0]     vowel_start;
  logic                            len_short;
  tnss_pkg::slot_t                 wr_data;
  logic                            wr_en;

  assign len_short   = note_i.note_length < onset_i;
  assign first_len   = (note_i.vowel_only || len_short) ? note_i.note_length : onset_i;
  assign vowel_len   = (len_short ? '0 : note_i.note_length - onset_i) + trans_i;
  assign vowel_start = note_i.start_time + tnss_pkg::TIME_W'(onset_i)
                       - tnss_pkg::TIME_W'(trans_i);

  assign wr_en = cmd_i.wr_first | cmd_i.wr_second;
  always_comb begin
    if (cmd_i.wr_second) begin
      wr_data = vowel_q;
    end else begin
      wr_data.sound  = note_i.onset_sound;
      wr_data.start  = note_i.start_time;
      wr_data.length = first_len;
      wr_data.pitch  = note_i.pitch;
    end
  end

  // memory write at the write pointer, read at the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= wr_data;
    end
    rd_q <= mem[idx_q];
  end

  // latched item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q          <= note_i.now_time;
      vowel_q.sound  <= note_i.vowel_sound;
      vowel_q.start  <= vowel_start;
      vowel_q.length <= vowel_len;
      vowel_q.pitch  <= note_i.pitch;
    end
  end

  // slot decision for the current scan index
  logic [1:0]                  need;
  logic [CW:0]                 cnt_need;
  logic [tnss_pkg::TIME_W:0]   stop_time;
  logic                        do_start, do_stop;

  assign do_start  = !started_q[idx_q];
  assign stop_time = (tnss_pkg::TIME_W+1)'(rd_q.start) + (tnss_pkg::TIME_W+1)'(rd_q.length);
  assign do_stop   = {1'b0, now_q} >= stop_time;
  assign need      = {1'b0, do_start} + {1'b0, do_stop};
  assign cnt_need  = (CW+1)'(cnt_q) + (CW+1)'(need);

  assign out_free = !out_v_q || evt_o.ready;

  always_comb begin
    sts_o.func       = note_i.func;
    sts_o.vowel_only = note_i.vowel_only;
    sts_o.eligible   = playing_q[idx_q] && (now_q >= rd_q.start) &&
                       (cnt_need <= (CW+1)'(tnss_pkg::MAX_EVENTS));
    sts_o.do_start   = do_start;
    sts_o.do_stop    = do_stop;
    sts_o.can_push   = !pend_v_q || out_free;
    sts_o.idx_last   = idx_q == SW'(tnss_pkg::SLOT_COUNT - 1);
    sts_o.pend_v     = pend_v_q;
  end

  // event built from the current slot
  assign push = cmd_i.push_start | cmd_i.push_stop;
  always_comb begin
    push_ev.slot = tnss_pkg::SLOTF_W'(idx_q);
    if (cmd_i.push_start) begin
      push_ev.kind  = tnss_pkg::EV_START;
      push_ev.sound = rd_q.sound;
      push_ev.pitch = rd_q.pitch;
    end else begin
      push_ev.kind  = tnss_pkg::EV_STOP;
      push_ev.sound = '0;
      push_ev.pitch = '0;
    end
  end

  // control state next values
  always_comb begin
    playing_d = playing_q;
    started_d = started_q;
    wp_d      = wp_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    pend_v_d  = pend_v_q;
    out_v_d   = out_v_q && !evt_o.ready;
    load_out  = 1'b0;

    if (wr_en) begin
      playing_d[wp_q] = 1'b1;
      started_d[wp_q] = 1'b0;
      wp_d = (wp_q == SW'(tnss_pkg::SLOT_COUNT - 1)) ? '0 : wp_q + SW'(1);
    end
    if (cmd_i.load && note_i.func == tnss_pkg::FUNC_TICK) begin
      idx_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + SW'(1);
    end
    if (cmd_i.push_start) begin
      started_d[idx_q] = 1'b1;
    end
    if (cmd_i.push_stop) begin
      playing_d[idx_q] = 1'b0;
    end
    if (push) begin
      cnt_d    = cnt_q + CW'(1);
      pend_v_d = 1'b1;
    end
    if ((push || cmd_i.flush) && pend_v_q) begin
      load_out = 1'b1;
      out_v_d  = 1'b1;
    end
    if (cmd_i.flush) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= '0;
      started_q <= '0;
      wp_q      <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      playing_q <= playing_d;
      started_q <= started_d;
      wp_q      <= wp_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // pending event and output register
  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_q <= push_ev;
    end
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign note_i.ready     = in_ready_i;
  assign evt_o.valid      = out_v_q;
  assign evt_o.event_kind = out_q.kind;
  assign evt_o.slot       = out_q.slot;
  assign evt_o.sound      = out_q.sound;
  assign evt_o.pitch_out  = out_q.pitch;
  assign evt_o.last       = out_last_q;

  // controller never pushes over an event that has nowhere to go
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push || cmd_i.flush) |-> (!pend_v_q || out_free))
    else $error("event pushed while pending and output are both full");

  // a flush of a held event leaves it on the output marked last
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.flush && pend_v_q) |=> (out_v_q && out_last_q && !pend_v_q))
    else $error("flushed event not shown as last");

  // the tick event count stays within the result limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(tnss_pkg::MAX_EVENTS))
    else $error("event count over limit");

  // stop events only come from playing slots
  a_stop_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_stop |-> playing_q[idx_q])
    else $error("stop event for an idle slot");

  // nothing is left pending when a new item is taken
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !pend_v_q)
    else $error("item taken with an event still pending");

endmodule

@@ design/timed_note_slot_scheduler_top.sv @@
// Timed note slot scheduler: a ring of tnss_pkg::SLOT_COUNT note slots. An add item writes one
// slot for a bare vowel and two for an onset syllable (one slot write per cycle into the slot
// store). A tick item scans the slots one at a time: each slot is read and then evaluated, a
// slot that emits a stop takes a further stop step, and a flush step closes the tick. The single
// read port of the slot store and the one-deep pending event stage set this step-by-step pace;
// the pending stage holds each event until the next one shows whether it is the last of the tick.
// Events leave through an output register, and the next item is taken while the final event of
// a tick still waits there. The onset length register sits at byte address 0 and the onset
// overlap register at 4.
module timed_note_slot_scheduler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tnss_note_if.sink                      note_i,
  tnss_evt_if.source                     evt_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tnss_pkg::PADDR_W-1:0]   paddr,
  input  logic [tnss_pkg::PDATA_W-1:0]   pwdata,
  output logic [tnss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [tnss_pkg::LEN_W-1:0] onset_q, trans_q;
  logic                       cfg_wr, in_ready;
  logic                       reg_sel;
  tnss_pkg::ctrl_cmd_t        cmd;
  tnss_pkg::dp_status_t       sts;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      onset_q <= tnss_pkg::LEN_W'(4);
      trans_q <= tnss_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      if (reg_sel == tnss_pkg::REG_ONSET) begin
        onset_q <= pwdata[tnss_pkg::LEN_W-1:0];
      end else begin
        trans_q <= pwdata[tnss_pkg::LEN_W-1:0];
      end
    end
  end

  // register read
  always_comb begin
    if (reg_sel == tnss_pkg::REG_ONSET) begin
      prdata = tnss_pkg::PDATA_W'(onset_q);
    end else begin
      prdata = tnss_pkg::PDATA_W'(trans_q);
    end
  end

  tnss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (note_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tnss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .note_i     (note_i),
    .evt_o      (evt_o),
    .in_ready_i (in_ready),
    .onset_i    (onset_q),
    .trans_i    (trans_q),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

@@ bench/tb_timed_note_slot_scheduler_top.sv @@
`timescale 1ns / 100ps

module tb_timed_note_slot_scheduler_top;

  // longest tick (read, evaluate, stop per slot, closing) plus output register margin
  localparam int SETTLE_CYCLES = 4 * tnss_pkg::SLOT_COUNT + 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASE_COUNT   = 6;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic                          func;
    logic [tnss_pkg::TIME_W-1:0]   now_time;
    logic [tnss_pkg::TIME_W-1:0]   start_time;
    logic [tnss_pkg::LEN_W-1:0]    note_length;
    logic [tnss_pkg::PITCH_W-1:0]  pitch;
    logic [tnss_pkg::SOUND_W-1:0]  onset_sound;
    logic [tnss_pkg::SOUND_W-1:0]  vowel_sound;
    logic                          vowel_only;
  } note_item_t;

  typedef struct packed {
    logic                          kind;
    logic [tnss_pkg::SLOTF_W-1:0]  slot;
    logic [tnss_pkg::SOUND_W-1:0]  sound;
    logic [tnss_pkg::PITCH_W-1:0]  pitch;
    logic                          last;
  } slot_event_t;

  // one row of stimulus, with the events typed in where they are obvious
  typedef struct {
    note_item_t  item;
    bit          typed;
    int          n_typed;
    slot_event_t ev0;
    slot_event_t ev1;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [tnss_pkg::PADDR_W-1:0]  paddr;
  logic [tnss_pkg::PDATA_W-1:0]  pwdata;
  logic [tnss_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  tnss_note_if note_bus ();
  tnss_evt_if  evt_bus ();

  timed_note_slot_scheduler_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .note_i  (note_bus),
    .evt_o   (evt_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the slot ring and its settings
  logic [tnss_pkg::LEN_W-1:0]   onset_len;
  logic [tnss_pkg::LEN_W-1:0]   overlap_len;
  logic [tnss_pkg::SOUND_W-1:0] ring_sound   [tnss_pkg::SLOT_COUNT];
  logic [tnss_pkg::TIME_W-1:0]  ring_start   [tnss_pkg::SLOT_COUNT];
  logic [tnss_pkg::LEN_W-1:0]   ring_length  [tnss_pkg::SLOT_COUNT];
  logic [tnss_pkg::PITCH_W-1:0] ring_pitch   [tnss_pkg::SLOT_COUNT];
  bit                           ring_started [tnss_pkg::SLOT_COUNT];
  bit                           ring_playing [tnss_pkg::SLOT_COUNT];
  int unsigned                  wr_slot;

  slot_event_t due_events[$];
  slot_event_t tick_events[$];
  stim_row_t   dir_rows[$];

  int unsigned err_cnt;
  int unsigned hold_req_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void log_fail(string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [tnss_pkg::PADDR_W-1:0] reg_addr(logic idx);
    return tnss_pkg::PADDR_W'({idx, 2'b00});
  endfunction

  function automatic note_item_t add_item(logic [tnss_pkg::TIME_W-1:0] st,
                                          logic [tnss_pkg::LEN_W-1:0] len,
                                          logic [tnss_pkg::PITCH_W-1:0] p,
                                          logic [tnss_pkg::SOUND_W-1:0] osnd,
                                          logic [tnss_pkg::SOUND_W-1:0] vsnd,
                                          logic vonly);
    note_item_t it;
    it = '0;
    it.func        = tnss_pkg::FUNC_ADD;
    it.start_time  = st;
    it.note_length = len;
    it.pitch       = p;
    it.onset_sound = osnd;
    it.vowel_sound = vsnd;
    it.vowel_only  = vonly;
    return it;
  endfunction

  function automatic note_item_t tick_item(logic [tnss_pkg::TIME_W-1:0] now);
    note_item_t it;
    it = '0;
    it.func     = tnss_pkg::FUNC_TICK;
    it.now_time = now;
    return it;
  endfunction

  function automatic slot_event_t mk_event(logic kind, logic [tnss_pkg::SLOTF_W-1:0] slot,
                                           logic [tnss_pkg::SOUND_W-1:0] snd,
                                           logic [tnss_pkg::PITCH_W-1:0] p,
                                           logic last);
    slot_event_t ev;
    ev.kind  = kind;
    ev.slot  = slot;
    ev.sound = snd;
    ev.pitch = p;
    ev.last  = last;
    return ev;
  endfunction

  function automatic void dir_row(note_item_t it, bit typed, int n, slot_event_t ev0,
                                  slot_event_t ev1);
    stim_row_t row;
    row.item    = it;
    row.typed   = typed;
    row.n_typed = n;
    row.ev0     = ev0;
    row.ev1     = ev1;
    dir_rows.push_back(row);
  endfunction

  // write one slot at the ring pointer, busy or not
  function automatic void fill_ring(logic [tnss_pkg::SOUND_W-1:0] snd,
                                    logic [tnss_pkg::TIME_W-1:0] st,
                                    logic [tnss_pkg::LEN_W-1:0] len,
                                    logic [tnss_pkg::PITCH_W-1:0] p);
    ring_sound[wr_slot]   = snd;
    ring_start[wr_slot]   = st;
    ring_length[wr_slot]  = len;
    ring_pitch[wr_slot]   = p;
    ring_started[wr_slot] = 1'b0;
    ring_playing[wr_slot] = 1'b1;
    wr_slot = (wr_slot + 1) % tnss_pkg::SLOT_COUNT;
  endfunction

  // apply one note item to the shadow ring, leaving the events of a tick in tick_events
  function automatic void play_note_item(note_item_t it);
    logic [tnss_pkg::TIME_W:0] stop_at;
    bit                        do_start;
    bit                        do_stop;
    tick_events.delete();
    if (it.func == tnss_pkg::FUNC_ADD) begin
      if (it.vowel_only) begin
        fill_ring(it.onset_sound, it.start_time, it.note_length, it.pitch);
      end else begin
        fill_ring(it.onset_sound, it.start_time,
                  (it.note_length < onset_len) ? it.note_length : onset_len, it.pitch);
        // vowel start wraps at the time width, its length at the length width
        fill_ring(it.vowel_sound, it.start_time + onset_len - overlap_len,
                  ((it.note_length < onset_len) ? tnss_pkg::LEN_W'(0)
                                                : it.note_length - onset_len)
                    + overlap_len,
                  it.pitch);
      end
    end else begin
      for (int i = 0; i < tnss_pkg::SLOT_COUNT; i++) begin
        if (ring_playing[i] && it.now_time >= ring_start[i]) begin
          // end time is formed one bit wider, without wrapping
          stop_at  = {1'b0, ring_start[i]} + {3'b000, ring_length[i]};
          do_start = !ring_started[i];
          do_stop  = {1'b0, it.now_time} >= stop_at;
          if (tick_events.size() + int'(do_start) + int'(do_stop) <= tnss_pkg::MAX_EVENTS)
          begin
            if (do_start) begin
              tick_events.push_back(mk_event(tnss_pkg::EV_START,
                                             tnss_pkg::SLOTF_W'(i), ring_sound[i],
                                             ring_pitch[i], 1'b0));
              ring_started[i] = 1'b1;
            end
            if (do_stop) begin
              tick_events.push_back(mk_event(tnss_pkg::EV_STOP, tnss_pkg::SLOTF_W'(i),
                                             '0, '0, 1'b0));
              ring_playing[i] = 1'b0;
            end
          end
        end
      end
      if (tick_events.size() > 0) begin
        tick_events[tick_events.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_note(input stim_row_t row);
    note_bus.valid       <= 1'b1;
    note_bus.func        <= row.item.func;
    note_bus.now_time    <= row.item.now_time;
    note_bus.start_time  <= row.item.start_time;
    note_bus.note_length <= row.item.note_length;
    note_bus.pitch       <= row.item.pitch;
    note_bus.onset_sound <= row.item.onset_sound;
    note_bus.vowel_sound <= row.item.vowel_sound;
    note_bus.vowel_only  <= row.item.vowel_only;
    @(posedge clk_i);
    while (!note_bus.ready) @(posedge clk_i);
    play_note_item(row.item);
    if (row.typed) begin
      if (row.n_typed > 0) due_events.push_back(row.ev0);
      if (row.n_typed > 1) due_events.push_back(row.ev1);
    end else begin
      foreach (tick_events[k]) due_events.push_back(tick_events[k]);
    end
  endtask

  // bursts of back-to-back items separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      note_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // stop sending and let every due event come out
  task automatic drain_events();
    note_bus.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register transfer; psel stays high so transfers can run back to back
  task automatic reg_access(input bit wr, input logic idx,
                            input logic [tnss_pkg::LEN_W-1:0] val,
                            output logic [tnss_pkg::PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(idx);
    pwdata  <= tnss_pkg::PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
  endtask

  task automatic read_check(input logic idx, input logic [tnss_pkg::LEN_W-1:0] want);
    logic [tnss_pkg::PDATA_W-1:0] rd;
    reg_access(1'b0, idx, '0, rd);
    if (rd !== tnss_pkg::PDATA_W'(want)) begin
      log_fail($sformatf("register %0d readback: expected %0d, got %0d", idx, want, rd));
    end
  endtask

  // write and read back; the caller ends the transfer run
  task automatic write_reg(input logic idx, input logic [tnss_pkg::LEN_W-1:0] val);
    logic [tnss_pkg::PDATA_W-1:0] rd;
    reg_access(1'b1, idx, val, rd);
    if (idx == tnss_pkg::REG_ONSET) onset_len = val;
    else overlap_len = val;
    read_check(idx, val);
  endtask

  // event receiver: changing stall patterns, plus a long hold on request
  initial begin : event_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    mode          = 0;
    mode_left     = 0;
    hold_left     = 0;
    hold_seen     = 0;
    evt_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        evt_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: begin
            evt_bus.ready <= 1'b1;
          end
          1: begin
            evt_bus.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            evt_bus.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // compare each event taken against the oldest one due
  always @(posedge clk_i) begin : event_check
    slot_event_t got;
    slot_event_t want;
    if (rst_ni && evt_bus.valid && evt_bus.ready) begin
      got = mk_event(evt_bus.event_kind, evt_bus.slot, evt_bus.sound, evt_bus.pitch_out,
                     evt_bus.last);
      if (due_events.size() == 0) begin
        log_fail($sformatf("unexpected event: kind %0d slot %0d sound %0d pitch %0d last %0d",
                           got.kind, got.slot, got.sound, $signed(got.pitch), got.last));
      end else begin
        want = due_events.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.sound !== want.sound ||
            got.pitch !== want.pitch || got.last !== want.last) begin
          log_fail($sformatf({"event mismatch: expected kind %0d slot %0d sound %0d ",
                              "pitch %0d last %0d, got kind %0d slot %0d sound %0d ",
                              "pitch %0d last %0d"},
                             want.kind, want.slot, want.sound, $signed(want.pitch), want.last,
                             got.kind, got.slot, got.sound, $signed(got.pitch), got.last));
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((note_bus.valid && note_bus.ready) || (evt_bus.valid && evt_bus.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timed_note_slot_scheduler_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t                    row;
    logic [tnss_pkg::TIME_W-1:0]  sim_now;
    logic [tnss_pkg::LEN_W-1:0]   onset_set [PHASE_COUNT];
    logic [tnss_pkg::LEN_W-1:0]   trans_set [PHASE_COUNT];
    int unsigned                  roll;

    // known levels from time zero
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    note_bus.valid        = 1'b0;
    note_bus.func         = tnss_pkg::FUNC_ADD;
    note_bus.now_time     = '0;
    note_bus.start_time   = '0;
    note_bus.note_length  = '0;
    note_bus.pitch        = '0;
    note_bus.onset_sound  = '0;
    note_bus.vowel_sound  = '0;
    note_bus.vowel_only   = 1'b0;
    err_cnt               = 0;
    hold_req_cnt          = 0;
    idle_cycles           = 0;
    burst_left            = 0;
    sim_now               = '0;

    // shadow state after reset
    onset_len   = 16'd4;
    overlap_len = 16'd1;
    wr_slot     = 0;
    for (int i = 0; i < tnss_pkg::SLOT_COUNT; i++) begin
      ring_sound[i]   = '0;
      ring_start[i]   = '0;
      ring_length[i]  = '0;
      ring_pitch[i]   = '0;
      ring_started[i] = 1'b0;
      ring_playing[i] = 1'b0;
    end

    // phase settings: reset values, extremes, overlap past onset, random, short onset
    onset_set[0] = 16'd4;     trans_set[0] = 16'd1;
    onset_set[1] = 16'd0;     trans_set[1] = 16'd0;
    onset_set[2] = 16'hFFFF;  trans_set[2] = 16'hFFFF;
    onset_set[3] = 16'd2;     trans_set[3] = 16'd7;
    onset_set[4] = tnss_pkg::LEN_W'($urandom_range(1, 40));
    trans_set[4] = tnss_pkg::LEN_W'($urandom_range(0, onset_set[4]));
    onset_set[5] = 16'd1;     trans_set[5] = 16'd0;

    // directed table
    // nothing playing after reset
    dir_row(tick_item('0), 1'b1, 0, '0, '0);
    // bare vowel, zero length, most negative pitch: starts and stops at once
    dir_row(add_item('0, '0, 16'h8000, 8'hFF, 8'h00, 1'b1), 1'b0, 0, '0, '0);
    dir_row(tick_item('0), 1'b1, 2,
            mk_event(tnss_pkg::EV_START, 4'd0, 8'hFF, 16'h8000, 1'b0),
            mk_event(tnss_pkg::EV_STOP, 4'd0, 8'h00, 16'h0000, 1'b1));
    // onset syllable shorter than the onset part
    dir_row(add_item(18'd10, 16'd2, 16'h7FFF, 8'h5A, 8'hA5, 1'b0), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'd9), 1'b1, 0, '0, '0);
    dir_row(tick_item(18'd10), 1'b1, 1,
            mk_event(tnss_pkg::EV_START, 4'd1, 8'h5A, 16'h7FFF, 1'b1), '0);
    dir_row(tick_item(18'd13), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'd14), 1'b0, 0, '0, '0);
    // latest start and longest note: vowel start wraps, end time needs the extra bit
    dir_row(add_item(18'h3FFFF, 16'hFFFF, 16'h0000, 8'h00, 8'hFF, 1'b0), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'h3FFFF), 1'b0, 0, '0, '0);
    // fill the ring past its end so the write pointer wraps
    dir_row(add_item('0, 16'd0, 16'h1234, 8'h11, 8'h22, 1'b0), 1'b0, 0, '0, '0);
    dir_row(add_item('0, 16'd3, 16'hFEDC, 8'h33, 8'h44, 1'b0), 1'b0, 0, '0, '0);
    dir_row(add_item('0, 16'd4, 16'h0001, 8'h55, 8'h66, 1'b0), 1'b0, 0, '0, '0);
    dir_row(add_item('0, 16'd5, 16'hFFFF, 8'h77, 8'h88, 1'b0), 1'b0, 0, '0, '0);
    dir_row(add_item('0, 16'hFFFF, 16'h5555, 8'h99, 8'hAA, 1'b0), 1'b0, 0, '0, '0);
    dir_row(add_item('0, 16'd1, 16'hAAAA, 8'hBB, 8'hCC, 1'b0), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'h20000), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'h3FFFF), 1'b0, 0, '0, '0);
    dir_row(tick_item(18'h3FFFF), 1'b0, 0, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values after reset
    read_check(tnss_pkg::REG_ONSET, 16'd4);
    read_check(tnss_pkg::REG_TRANS, 16'd1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_note(dir_rows[r]);
      pace_sender();
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_events();
      write_reg(tnss_pkg::REG_ONSET, onset_set[ph]);
      write_reg(tnss_pkg::REG_TRANS, trans_set[ph]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      // long receiver hold while items keep coming
      if (ph == 0) hold_req_cnt++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll                     = $urandom_range(0, 99);
        row.typed                = 1'b0;
        row.n_typed              = 0;
        row.ev0                  = '0;
        row.ev1                  = '0;
        row.item.func            = 1'($urandom_range(0, 1));
        row.item.now_time        = tnss_pkg::TIME_W'($urandom);
        row.item.start_time      = tnss_pkg::TIME_W'($urandom);
        row.item.note_length     = tnss_pkg::LEN_W'($urandom);
        row.item.pitch           = tnss_pkg::PITCH_W'($urandom);
        row.item.onset_sound     = tnss_pkg::SOUND_W'($urandom);
        row.item.vowel_sound     = tnss_pkg::SOUND_W'($urandom);
        row.item.vowel_only      = 1'($urandom_range(0, 1));
        if (roll >= 8 && roll < 58) begin
          // note starting soon, mostly short
          row.item.func       = tnss_pkg::FUNC_ADD;
          row.item.start_time = sim_now + tnss_pkg::TIME_W'($urandom_range(0, 24));
          if ($urandom_range(0, 9) != 0) begin
            row.item.note_length = tnss_pkg::LEN_W'($urandom_range(0, 24));
          end
          row.item.vowel_only = ($urandom_range(0, 3) == 0);
        end else if (roll >= 58) begin
          // time moves forward a little
          sim_now           = sim_now + tnss_pkg::TIME_W'($urandom_range(0, 10));
          row.item.func     = tnss_pkg::FUNC_TICK;
          row.item.now_time = sim_now;
        end
        send_note(row);
        pace_sender();
      end
    end

    drain_events();
    if (err_cnt == 0) begin
      $display("timed_note_slot_scheduler_top test passed");
    end else begin
      $display("timed_note_slot_scheduler_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tnss_pkg.sv
design/tnss_note_if.sv
design/tnss_evt_if.sv
design/tnss_ctrl.sv
design/tnss_dp.sv
design/timed_note_slot_scheduler_top.sv
bench/tb_timed_note_slot_scheduler_top.sv
